// ===== rtl/core/scoped_bump_allocator_macros.svh =====
// Assertion shorthands shared by the allocator RTL
`ifndef SCOPED_BUMP_ALLOCATOR_MACROS_SVH
`define SCOPED_BUMP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle, out of reset
`define SBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/sba_pkg.sv =====
package sba_pkg;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_POP   = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO_SIZE  = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_DEPTH_FULL = 3'd3,
    ST_POP_EMPTY  = 3'd4
  } status_t;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 8'd1;

  localparam logic [31:0] CAPACITY_RESET = 32'd4096;
  localparam logic [31:0] BASE_RESET     = 32'd0;

  localparam int unsigned ALIGN_W = 15;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] alloc_size;
    logic [3:0]  align_log2;
    logic [31:0] reserve_bytes;
  } in_t;

  typedef struct packed {
    logic        ok;
    status_t     status;
    logic [32:0] address;
    logic [31:0] used_bytes;
  } out_t;

  // shift control for the mark chain
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

// ===== rtl/core/scoped_bump_allocator.sv =====
// Scoped bump allocator.
// Commands arrive on in_data and are taken at a clock edge where start is high
// and busy is low. Each command yields one result beat on out_data, marked by
// out_valid for a single cycle; the receiver has no way to stall it.
// A command passes an evaluate stage (fit checks, aligned start) and then a commit
// stage (cursor update, mark chain shift); out_valid and out_data are registered
// from the commit stage. busy is high only in the evaluate cycle, so a new command
// can be taken while the previous one commits.
// Region size and base address are written through cfg_* (index 0 capacity,
// index 1 base); cfg_ready is always high, write only while idle.
// Scope marks live in a row of shift cells, newest at the head; a push shifts
// the row down, a pop shifts it up and restores the cursor from the head.
// After reset: cursor and depth 0, capacity 4096, base 0, no result pending.
// Marks are not cleared and no clearing pass is needed.
module scoped_bump_allocator
  import sba_pkg::*;
#(
  parameter int unsigned MAX_SCOPES  = 16,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_valid,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int unsigned CW = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
  localparam int unsigned DW = $clog2(MAX_SCOPES + 1);
  localparam logic [CW-1:0] CAP_LIM    = '1;
  localparam logic [DW-1:0] DEPTH_FULL = DW'(MAX_SCOPES);

  // configuration
  logic [31:0] capacity_r, capacity_nxt;
  logic [31:0] base_r,     base_nxt;

  // architectural state
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [DW-1:0] depth_r,  depth_nxt;

  // evaluate stage
  logic          ph1_r;
  in_t           in_r;

  // commit stage
  logic          ph2_r;
  cmd_t          p2_cmd_r;
  logic          p2_ok_r;
  status_t       p2_status_r;
  logic [32:0]   p2_start_r;
  logic [ALIGN_W-1:0] p2_pad_r;
  logic [31:0]   p2_size_r;

  logic          out_valid_r;
  out_t          out_r, out_nxt;

  // evaluate logic
  logic [CW-1:0]      cap_eff;
  logic [ALIGN_W-1:0] amask;
  logic [33:0]        fit_sum;
  logic [32:0]        res_sum;
  logic [32:0]        start_sum;
  logic [ALIGN_W-1:0] pad;
  logic               ev_ok;
  status_t            ev_status;

  // commit logic
  logic [33:0]   grow_sum;
  logic [CW-1:0] top_mark;
  stk_ctl_t      stk_ctl;

  assign cfg_ready = 1'b1;
  assign busy      = ph1_r;

  always_comb begin
    capacity_nxt = capacity_r;
    base_nxt     = base_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_CAPACITY: capacity_nxt = cfg_data;
        REG_BASE:     base_nxt     = cfg_data;
        default:      ;
      endcase
    end
  end

  assign cap_eff = (capacity_r > 32'(CAP_LIM)) ? CAP_LIM : capacity_r[CW-1:0];
  assign amask   = ~({ALIGN_W{1'b1}} << in_r.align_log2);

  // worst case reserve, no wrap
  assign fit_sum   = 34'(cursor_r) + 34'(in_r.alloc_size) + 34'(amask);
  assign res_sum   = 33'(cursor_r) + 33'(in_r.reserve_bytes);
  assign start_sum = 33'(base_r) + 33'(cursor_r);
  assign pad       = (~start_sum[ALIGN_W-1:0] + ALIGN_W'(1)) & amask;

  always_comb begin
    ev_ok     = 1'b0;
    ev_status = ST_OK;
    unique case (in_r.cmd)
      CMD_ALLOC: begin
        if (in_r.alloc_size == 32'd0) begin
          ev_status = ST_ZERO_SIZE;
        end else if (fit_sum > 34'(cap_eff)) begin
          ev_status = ST_NO_SPACE;
        end else begin
          ev_ok = 1'b1;
        end
      end
      CMD_PUSH: begin
        if (depth_r >= DEPTH_FULL) begin
          ev_status = ST_DEPTH_FULL;
        end else if ((in_r.reserve_bytes != 32'd0) && (res_sum > 33'(cap_eff))) begin
          ev_status = ST_NO_SPACE;
        end else begin
          ev_ok = 1'b1;
        end
      end
      CMD_POP: begin
        if (depth_r == '0) begin
          ev_status = ST_POP_EMPTY;
        end else begin
          ev_ok = 1'b1;
        end
      end
      CMD_RESET: ev_ok = 1'b1;
      default:   ev_status = ST_OK;
    endcase
  end

  // commit logic
  assign grow_sum = 34'(cursor_r) + 34'(p2_pad_r) + 34'(p2_size_r);

  always_comb begin
    cursor_nxt   = cursor_r;
    depth_nxt    = depth_r;
    stk_ctl.push = 1'b0;
    stk_ctl.pop  = 1'b0;
    if (ph2_r && p2_ok_r) begin
      case (p2_cmd_r)
        CMD_ALLOC: cursor_nxt = grow_sum[CW-1:0];
        CMD_PUSH: begin
          depth_nxt    = depth_r + DW'(1);
          stk_ctl.push = 1'b1;
        end
        CMD_POP: begin
          depth_nxt   = depth_r - DW'(1);
          cursor_nxt  = top_mark;
          stk_ctl.pop = 1'b1;
        end
        default: begin
          cursor_nxt = '0;
          depth_nxt  = '0;
        end
      endcase
    end
  end

  always_comb begin
    out_nxt.ok         = p2_ok_r;
    out_nxt.status     = p2_status_r;
    out_nxt.address    = '0;
    out_nxt.used_bytes = 32'(cursor_nxt);
    if (p2_ok_r && (p2_cmd_r == CMD_ALLOC)) begin
      out_nxt.address = p2_start_r + 33'(p2_pad_r);
    end
  end

  sba_mark_chain #(
    .DEPTH (MAX_SCOPES),
    .W     (CW)
  ) u_marks (
    .clk       (clk),
    .ctl       (stk_ctl),
    .push_mark (cursor_r),
    .top_mark  (top_mark)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAPACITY_RESET;
      base_r      <= BASE_RESET;
      cursor_r    <= '0;
      depth_r     <= '0;
      ph1_r       <= 1'b0;
      ph2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      capacity_r  <= capacity_nxt;
      base_r      <= base_nxt;
      cursor_r    <= cursor_nxt;
      depth_r     <= depth_nxt;
      ph1_r       <= start && !busy;
      ph2_r       <= ph1_r;
      out_valid_r <= ph2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
    if (ph1_r) begin
      p2_cmd_r    <= in_r.cmd;
      p2_ok_r     <= ev_ok;
      p2_status_r <= ev_status;
      p2_start_r  <= start_sum;
      p2_pad_r    <= pad;
      p2_size_r   <= in_r.alloc_size;
    end
    if (ph2_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "scoped_bump_allocator_macros.svh"

  `SBA_ASSERT_NOW(a_depth_bound, 1'b1, depth_r <= DEPTH_FULL, "scope depth beyond limit")
  `SBA_ASSERT_NOW(a_result_latency, start && !busy, ##3 out_valid, "result beat missing")
  `SBA_ASSERT_NOW(a_ok_status, out_valid, out_data.ok == (out_data.status == ST_OK),
                  "ok flag disagrees with status")
  `SBA_ASSERT_NOW(a_fail_addr, out_valid && !out_data.ok, out_data.address == '0,
                  "address on failed command")
  `SBA_ASSERT_NEXT(a_stall_idle, ph1_r, !ph1_r, "evaluate stage held over")

endmodule

// ===== rtl/core/sba_mark_cell.sv =====
module sba_mark_cell
  import sba_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  stk_ctl_t     ctl,
  input  logic [W-1:0] from_up,
  input  logic [W-1:0] from_down,
  output logic [W-1:0] mark
);

  logic [W-1:0] mark_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mark_r <= from_up;
    end else if (ctl.pop) begin
      mark_r <= from_down;
    end
  end

  assign mark = mark_r;

endmodule

// ===== rtl/core/sba_mark_chain.sv =====
module sba_mark_chain
  import sba_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned W     = 32
) (
  input  logic         clk,
  input  stk_ctl_t     ctl,
  input  logic [W-1:0] push_mark,
  output logic [W-1:0] top_mark
);

  logic [W-1:0] marks [DEPTH];

  // cell 0 is the newest mark; a push moves every mark one cell down
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] up_d;
    logic [W-1:0] down_d;

    if (i == 0) begin : g_head
      assign up_d = push_mark;
    end else begin : g_body
      assign up_d = marks[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign down_d = marks[i];
    end else begin : g_mid
      assign down_d = marks[i+1];
    end

    sba_mark_cell #(
      .W (W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_up   (up_d),
      .from_down (down_d),
      .mark      (marks[i])
    );
  end

  assign top_mark = marks[0];

endmodule
